// ===== sv/afr_pkg.sv =====
package afr_pkg;

	localparam int MAX_FRAME  = 32;
	localparam int COUNT_W    = 6;
	localparam int TICK_W     = 16;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]         HEADER_BYTE      = 8'hFB;
	localparam logic [COUNT_W-1:0] MIN_FRAME        = COUNT_W'(5);
	localparam logic [COUNT_W-1:0] MAX_FRAME_LEN    = COUNT_W'(MAX_FRAME);
	localparam logic [COUNT_W-1:0] STATUS_COUNT     = COUNT_W'(4);
	localparam logic [COUNT_W-1:0] RST_FRAME_LENGTH = COUNT_W'(5);
	localparam logic [TICK_W-1:0]  RST_TIMEOUT      = TICK_W'(100);
	localparam logic [TICK_W-1:0]  TICK_MAX         = '1;

	typedef enum logic [0:0] {
		CFG_FRAME_LENGTH  = 1'b0,
		CFG_TIMEOUT_TICKS = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_BYTE  = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [0:0] {
		OUTCOME_FRAME   = 1'b0,
		OUTCOME_TIMEOUT = 1'b1
	} outcome_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		outcome_t   outcome;
		logic [7:0] status_byte;
	} out_item_t;

	typedef struct packed {
		logic               armed;
		logic [COUNT_W-1:0] byte_count;
		logic [7:0]         running_sum;
		logic [7:0]         captured_status;
		logic [TICK_W-1:0]  elapsed_ticks;
	} rx_state_t;

endpackage

// ===== sv/afr_step.sv =====
module afr_step (
	input  afr_pkg::rx_state_t                 st,
	input  afr_pkg::in_item_t                  item,
	input  logic [afr_pkg::COUNT_W-1:0]        frame_length,
	input  logic [afr_pkg::TICK_W-1:0]         timeout_ticks,
	output afr_pkg::rx_state_t                 st_nxt,
	output logic                               emit,
	output afr_pkg::out_item_t                 res
);
	import afr_pkg::*;

	logic [COUNT_W-1:0] len;
	logic [COUNT_W-1:0] count_inc;
	logic [TICK_W-1:0]  ticks_inc;

	always_comb begin
		if (frame_length < MIN_FRAME) begin
			len = MIN_FRAME;
		end else if (frame_length > MAX_FRAME_LEN) begin
			len = MAX_FRAME_LEN;
		end else begin
			len = frame_length;
		end
	end

	assign count_inc = st.byte_count + COUNT_W'(1);
	assign ticks_inc = (st.elapsed_ticks != TICK_MAX) ? st.elapsed_ticks + TICK_W'(1)
		: st.elapsed_ticks;

	always_comb begin
		st_nxt          = st;
		emit            = 1'b0;
		res.outcome     = OUTCOME_FRAME;
		res.status_byte = st.captured_status;
		case (item.func)
			FUNC_START: begin
				st_nxt.armed           = 1'b1;
				st_nxt.byte_count      = '0;
				st_nxt.running_sum     = '0;
				st_nxt.captured_status = '0;
				st_nxt.elapsed_ticks   = '0;
				if (timeout_ticks == '0) begin
					emit                   = 1'b1;
					res.outcome            = OUTCOME_TIMEOUT;
					res.status_byte        = '0;
					st_nxt.armed           = 1'b0;
				end
			end
			FUNC_BYTE: begin
				if (st.armed && !(st.byte_count == '0 && item.byte_value != HEADER_BYTE)) begin
					if (count_inc >= len) begin
						st_nxt.byte_count  = '0;
						st_nxt.running_sum = '0;
						if (item.byte_value == st.running_sum) begin
							emit         = 1'b1;
							st_nxt.armed = 1'b0;
						end
					end else begin
						st_nxt.byte_count  = count_inc;
						st_nxt.running_sum = st.running_sum + item.byte_value;
						if (count_inc == STATUS_COUNT) begin
							st_nxt.captured_status = item.byte_value;
						end
					end
				end
			end
			FUNC_TICK: begin
				if (st.armed) begin
					st_nxt.elapsed_ticks = ticks_inc;
					if (ticks_inc >= timeout_ticks) begin
						emit            = 1'b1;
						res.outcome     = OUTCOME_TIMEOUT;
						res.status_byte = '0;
						st_nxt.armed    = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/ack_frame_receiver.sv =====
// Servo reply frame receiver.
// Input channel (in_valid/in_stall/in_item) carries start, byte and tick
// transactions; output channel (out_valid/out_stall/out_item) carries at most
// one result per input: a good frame with its status byte, or a timeout.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 frame length, 1 timeout ticks); the user is to write only while the
// block is idle, which the block itself does not enforce. An accepted
// input loads the input register; its result, if any, then loads the
// output register once free. Throughput: one input per cycle while in_stall
// is low, as the single state register is read and written in the same cycle.
// The output register is also the hold stage: while out_stall holds a
// pending result, the input register keeps its item and in_stall rises;
// a held-back item never overwrites a waiting result.
// Reset: receiver disarmed, counters cleared, frame length 5, timeout 100,
// both pipeline stages empty.
module ack_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  afr_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output afr_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  afr_pkg::cfg_index_t               cfg_index,
	input  logic [afr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import afr_pkg::*;

	logic               valid_s1;
	in_item_t           item_s1;
	logic               advance;
	rx_state_t          st_q;
	rx_state_t          st_nxt;
	logic               emit;
	out_item_t          res;
	logic [COUNT_W-1:0] frame_length_q;
	logic [TICK_W-1:0]  timeout_ticks_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q  <= RST_FRAME_LENGTH;
			timeout_ticks_q <= RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_LENGTH:  frame_length_q  <= cfg_data[COUNT_W-1:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	afr_step u_step (
		.st            (st_q),
		.item          (item_s1),
		.frame_length  (frame_length_q),
		.timeout_ticks (timeout_ticks_q),
		.st_nxt        (st_nxt),
		.emit          (emit),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== sv/afr_checker.sv =====
module afr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input afr_pkg::out_item_t  out_item
);
	import afr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted transaction");

endmodule

bind ack_frame_receiver afr_checker u_afr_checker (.*);
